/* design/psg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psg_pkg
// Shared widths, register addresses and item codes of the tone, noise and
// envelope generator.
// ----------------------------------------------------------------------------
package psg_pkg;

   localparam int NOISE_BITS_DEF = 17;

   localparam int STEP_W     = 2;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 8;
   localparam int LEVEL_W    = 4;
   localparam int ENV_LVL_W  = 5;
   localparam int TONE_CNT_W = 13;
   localparam int NOISE_CNT_W = 6;
   localparam int ENV_CNT_W  = 17;

   localparam logic [STEP_W-1:0] COUNT_STEP_RESET = 2'd2;

   // item codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // register map
   localparam logic [ADDR_W-1:0] REG_TONE_FINE_A   = 4'd0;
   localparam logic [ADDR_W-1:0] REG_TONE_COARSE_A = 4'd1;
   localparam logic [ADDR_W-1:0] REG_TONE_FINE_B   = 4'd2;
   localparam logic [ADDR_W-1:0] REG_TONE_COARSE_B = 4'd3;
   localparam logic [ADDR_W-1:0] REG_TONE_FINE_C   = 4'd4;
   localparam logic [ADDR_W-1:0] REG_TONE_COARSE_C = 4'd5;
   localparam logic [ADDR_W-1:0] REG_NOISE_PERIOD  = 4'd6;
   localparam logic [ADDR_W-1:0] REG_MIXER         = 4'd7;
   localparam logic [ADDR_W-1:0] REG_LEVEL_A       = 4'd8;
   localparam logic [ADDR_W-1:0] REG_LEVEL_B       = 4'd9;
   localparam logic [ADDR_W-1:0] REG_LEVEL_C       = 4'd10;
   localparam logic [ADDR_W-1:0] REG_ENV_FINE      = 4'd11;
   localparam logic [ADDR_W-1:0] REG_ENV_COARSE    = 4'd12;
   localparam logic [ADDR_W-1:0] REG_ENV_SHAPE     = 4'd13;

   localparam logic [ENV_LVL_W-1:0] ENV_STEP_TOP = 5'd31;

endpackage
`default_nettype wire

/* design/psg_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psg_req_if
// Input channel: register write or sample tick items.
// ----------------------------------------------------------------------------
interface psg_req_if import psg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [ADDR_W-1:0] reg_address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, func, reg_address, write_data, input ready);
   modport sink   (input valid, func, reg_address, write_data, output ready);
endinterface
`default_nettype wire

/* design/psg_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psg_rsp_if
// Result channel: per-channel gates, envelope selects and levels.
// ----------------------------------------------------------------------------
interface psg_rsp_if import psg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 gate_a;
   logic                 gate_b;
   logic                 gate_c;
   logic                 use_env_a;
   logic                 use_env_b;
   logic                 use_env_c;
   logic [LEVEL_W-1:0]   level_a;
   logic [LEVEL_W-1:0]   level_b;
   logic [LEVEL_W-1:0]   level_c;
   logic [ENV_LVL_W-1:0] env_level;

   modport source (output valid, gate_a, gate_b, gate_c, use_env_a, use_env_b,
                   use_env_c, level_a, level_b, level_c, env_level, input ready);
   modport sink   (input valid, gate_a, gate_b, gate_c, use_env_a, use_env_b,
                   use_env_c, level_a, level_b, level_c, env_level, output ready);
endinterface
`default_nettype wire

/* design/psg_csr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psg_csr_if
// Configuration write channel carrying the counter step.
// ----------------------------------------------------------------------------
interface psg_csr_if import psg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STEP_W-1:0] count_step;

   modport source (output valid, count_step, input ready);
   modport sink   (input valid, count_step, output ready);
endinterface
`default_nettype wire

/* design/psg_period_counter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psg_period_counter
// Next value of one period counter: add the step, wrap to zero and fire
// once the count reaches the period.
// ----------------------------------------------------------------------------
module psg_period_counter import psg_pkg::*; #(
   parameter int CNT_W = 13
) (
   input  wire logic [CNT_W-1:0]  count,
   input  wire logic [CNT_W-2:0]  period,
   input  wire logic [STEP_W-1:0] step,
   output logic      [CNT_W-1:0]  next_count,
   output logic                   fire
);
   logic [CNT_W-1:0] sum;

   // sum wraps at the counter width
   assign sum        = count + CNT_W'(step);
   assign fire       = (sum >= {1'b0, period});
   assign next_count = fire ? '0 : sum;
endmodule
`default_nettype wire

/* design/psg_tone_noise_envelope_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope_unit
// Three-channel tone, noise and envelope generator core.
// ----------------------------------------------------------------------------
// Each req item is a register write (func = 0) or a sample tick (func = 1).
// A write updates the register file and yields no rsp item; a tick advances
// the envelope, the noise prescaler/counter/LFSR and the three tone counters
// and yields one rsp item built from the updated state. One item is taken
// every clock unless the input stalls: an item sits in the input register,
// then its state update and result land in the output register together.
// The only stall is a tick in the input register while the output register
// still holds an untaken result.
// csr writes (count_step) are always ready and should only be issued while
// the block is idle.
// ----------------------------------------------------------------------------
module psg_tone_noise_envelope_unit import psg_pkg::*; #(
   parameter int NOISE_BITS = NOISE_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   psg_req_if.sink   req_chan,
   psg_rsp_if.source rsp_chan,
   psg_csr_if.sink   csr_chan
);

   localparam logic [NOISE_BITS-1:0] LFSR_SEED = NOISE_BITS'(1) << (NOISE_BITS - 1);

   // ---------------- configuration ----------------
   logic [STEP_W-1:0] count_step_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_step_ff <= COUNT_STEP_RESET;
      end else if (csr_chan.valid) begin
         count_step_ff <= csr_chan.count_step;
      end
   end

   // ---------------- input register ----------------
   logic              in_valid_ff;
   logic              in_func_ff;
   logic [ADDR_W-1:0] in_addr_ff;
   logic [DATA_W-1:0] in_data_ff;

   logic out_valid_ff;
   logic is_tick, consume, do_tick, do_write;

   assign is_tick  = (in_func_ff == FUNC_TICK);
   // writes never need the output register; ticks need it free
   assign consume  = in_valid_ff && (!is_tick || !out_valid_ff || rsp_chan.ready);
   assign do_tick  = consume && is_tick;
   assign do_write = consume && !is_tick;
   assign req_chan.ready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_func_ff <= req_chan.func;
         in_addr_ff <= req_chan.reg_address;
         in_data_ff <= req_chan.write_data;
      end
   end

   // ---------------- generator state ----------------
   logic [TONE_CNT_W-2:0]  tone_period_ff [3];
   logic [TONE_CNT_W-1:0]  tone_count_ff  [3];
   logic [2:0]             tone_out_ff;
   logic [2:0]             tone_off_ff;
   logic [2:0]             noise_off_ff;
   logic [LEVEL_W-1:0]     fixed_level_ff [3];
   logic [2:0]             env_enable_ff;
   logic [NOISE_CNT_W-2:0] noise_period_ff;
   logic [NOISE_CNT_W-1:0] noise_count_ff;
   logic                   noise_prescale_ff;
   logic                   noise_bit_ff;
   logic [NOISE_BITS-1:0]  lfsr_ff;
   logic [ENV_CNT_W-2:0]   env_period_ff;
   logic [ENV_CNT_W-1:0]   env_count_ff;
   logic [ENV_LVL_W-1:0]   env_step_ff;
   logic                   env_stepping_ff;
   logic                   env_hold_ff;
   logic                   env_alternate_ff;   // 1 flips the invert mask at each envelope end
   logic                   env_invert_ff;      // 1 stands for a mask of 31

   logic [TONE_CNT_W-2:0]  tone_period_in [3];
   logic [TONE_CNT_W-1:0]  tone_count_in  [3];
   logic [2:0]             tone_out_in;
   logic [2:0]             tone_off_in;
   logic [2:0]             noise_off_in;
   logic [LEVEL_W-1:0]     fixed_level_in [3];
   logic [2:0]             env_enable_in;
   logic [NOISE_CNT_W-2:0] noise_period_in;
   logic [NOISE_CNT_W-1:0] noise_count_in;
   logic                   noise_prescale_in;
   logic                   noise_bit_in;
   logic [NOISE_BITS-1:0]  lfsr_in;
   logic [ENV_CNT_W-2:0]   env_period_in;
   logic [ENV_CNT_W-1:0]   env_count_in;
   logic [ENV_LVL_W-1:0]   env_step_in;
   logic                   env_stepping_in;
   logic                   env_hold_in;
   logic                   env_alternate_in;
   logic                   env_invert_in;

   // ---------------- period counters ----------------
   logic [TONE_CNT_W-1:0]  tone_count_nx [3];
   logic [2:0]             tone_fire;
   logic [NOISE_CNT_W-1:0] noise_count_nx;
   logic                   noise_fire;
   logic [ENV_CNT_W-1:0]   env_count_nx;
   logic                   env_fire;

   for (genvar ch = 0; ch < 3; ch++) begin : g_tone
      psg_period_counter #(.CNT_W(TONE_CNT_W)) u_tone_cnt (
         .count      (tone_count_ff[ch]),
         .period     (tone_period_ff[ch]),
         .step       (count_step_ff),
         .next_count (tone_count_nx[ch]),
         .fire       (tone_fire[ch])
      );
   end

   psg_period_counter #(.CNT_W(NOISE_CNT_W)) u_noise_cnt (
      .count      (noise_count_ff),
      .period     (noise_period_ff),
      .step       (count_step_ff),
      .next_count (noise_count_nx),
      .fire       (noise_fire)
   );

   psg_period_counter #(.CNT_W(ENV_CNT_W)) u_env_cnt (
      .count      (env_count_ff),
      .period     (env_period_ff),
      .step       (count_step_ff),
      .next_count (env_count_nx),
      .fire       (env_fire)
   );

   // envelope step down; borrow out of the top marks the end of a cycle
   logic [ENV_LVL_W:0] env_dec;
   assign env_dec = {1'b0, env_step_ff} - (ENV_LVL_W + 1)'(env_stepping_ff);

   // LFSR: tap bits 0 and 3, feedback into the top
   logic lfsr_fb;
   assign lfsr_fb = lfsr_ff[3] ^ lfsr_ff[0];

   // ---------------- next state ----------------
   always_comb begin
      tone_period_in    = tone_period_ff;
      tone_count_in     = tone_count_ff;
      tone_out_in       = tone_out_ff;
      tone_off_in       = tone_off_ff;
      noise_off_in      = noise_off_ff;
      fixed_level_in    = fixed_level_ff;
      env_enable_in     = env_enable_ff;
      noise_period_in   = noise_period_ff;
      noise_count_in    = noise_count_ff;
      noise_prescale_in = noise_prescale_ff;
      noise_bit_in      = noise_bit_ff;
      lfsr_in           = lfsr_ff;
      env_period_in     = env_period_ff;
      env_count_in      = env_count_ff;
      env_step_in       = env_step_ff;
      env_stepping_in   = env_stepping_ff;
      env_hold_in       = env_hold_ff;
      env_alternate_in  = env_alternate_ff;
      env_invert_in     = env_invert_ff;

      if (do_tick) begin
         // envelope
         env_count_in = env_count_nx;
         if (env_fire) begin
            if (env_dec[ENV_LVL_W]) begin
               env_step_in     = ENV_STEP_TOP;
               env_stepping_in = ~env_hold_ff;
               env_invert_in   = env_invert_ff ^ env_alternate_ff;
            end else begin
               env_step_in = env_dec[ENV_LVL_W-1:0];
            end
         end
         // noise: counter runs on every second tick
         noise_prescale_in = ~noise_prescale_ff;
         if (noise_prescale_in) begin
            noise_count_in = noise_count_nx;
            if (noise_fire) begin
               noise_bit_in = lfsr_ff[0];
               lfsr_in      = {lfsr_fb, lfsr_ff[NOISE_BITS-1:1]};
            end
         end
         // tones
         for (int ch = 0; ch < 3; ch++) begin
            tone_count_in[ch] = tone_count_nx[ch];
            if (tone_fire[ch]) begin
               tone_out_in[ch] = ~tone_out_ff[ch];
            end
         end
      end else if (do_write) begin
         case (in_addr_ff)
            REG_TONE_FINE_A, REG_TONE_FINE_B, REG_TONE_FINE_C: begin
               tone_period_in[in_addr_ff[2:1]][7:0] = in_data_ff;
            end
            REG_TONE_COARSE_A, REG_TONE_COARSE_B, REG_TONE_COARSE_C: begin
               tone_period_in[in_addr_ff[2:1]][11:8] = in_data_ff[3:0];
            end
            REG_NOISE_PERIOD: begin
               noise_period_in = in_data_ff[NOISE_CNT_W-2:0];
            end
            REG_MIXER: begin
               tone_off_in  = in_data_ff[2:0];
               noise_off_in = in_data_ff[5:3];
            end
            REG_LEVEL_A, REG_LEVEL_B, REG_LEVEL_C: begin
               fixed_level_in[in_addr_ff[1:0]] = in_data_ff[LEVEL_W-1:0];
               env_enable_in[in_addr_ff[1:0]]  = in_data_ff[4];
            end
            REG_ENV_FINE: begin
               env_period_in[7:0] = in_data_ff;
            end
            REG_ENV_COARSE: begin
               env_period_in[15:8] = in_data_ff;
            end
            REG_ENV_SHAPE: begin
               // restart; bit 3 continue, bit 2 attack, bit 1 alternate, bit 0 hold
               env_count_in    = '0;
               env_step_in     = ENV_STEP_TOP;
               env_stepping_in = 1'b1;
               env_invert_in   = in_data_ff[2];
               if (in_data_ff[3]) begin
                  env_hold_in      = in_data_ff[0];
                  env_alternate_in = in_data_ff[0] ^ in_data_ff[1];
               end else begin
                  env_hold_in      = 1'b1;
                  env_alternate_in = ~in_data_ff[2];
               end
            end
            default: begin
               // registers 14 and 15: no effect
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < 3; ch++) begin
            tone_period_ff[ch] <= '0;
            tone_count_ff[ch]  <= '0;
            fixed_level_ff[ch] <= '0;
         end
         tone_out_ff       <= '0;
         tone_off_ff       <= '0;
         noise_off_ff      <= '0;
         env_enable_ff     <= '0;
         noise_period_ff   <= '0;
         noise_count_ff    <= '0;
         noise_prescale_ff <= 1'b0;
         noise_bit_ff      <= 1'b0;
         lfsr_ff           <= LFSR_SEED;
         env_period_ff     <= '0;
         env_count_ff      <= '0;
         env_step_ff       <= ENV_STEP_TOP;
         env_stepping_ff   <= 1'b1;
         env_hold_ff       <= 1'b1;
         env_alternate_ff  <= 1'b1;
         env_invert_ff     <= 1'b0;
      end else begin
         tone_period_ff    <= tone_period_in;
         tone_count_ff     <= tone_count_in;
         fixed_level_ff    <= fixed_level_in;
         tone_out_ff       <= tone_out_in;
         tone_off_ff       <= tone_off_in;
         noise_off_ff      <= noise_off_in;
         env_enable_ff     <= env_enable_in;
         noise_period_ff   <= noise_period_in;
         noise_count_ff    <= noise_count_in;
         noise_prescale_ff <= noise_prescale_in;
         noise_bit_ff      <= noise_bit_in;
         lfsr_ff           <= lfsr_in;
         env_period_ff     <= env_period_in;
         env_count_ff      <= env_count_in;
         env_step_ff       <= env_step_in;
         env_stepping_ff   <= env_stepping_in;
         env_hold_ff       <= env_hold_in;
         env_alternate_ff  <= env_alternate_in;
         env_invert_ff     <= env_invert_in;
      end
   end

   // ---------------- output register ----------------
   logic [2:0]           gate_in;
   logic [2:0]           gate_ff;
   logic [2:0]           use_env_ff;
   logic [LEVEL_W-1:0]   level_ff [3];
   logic [ENV_LVL_W-1:0] env_level_ff;

   // gates use the advanced tone/noise bits and the current mixer
   assign gate_in = (tone_out_in | tone_off_ff) & ({3{noise_bit_in}} | noise_off_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (do_tick) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_tick) begin
         gate_ff      <= gate_in;
         use_env_ff   <= env_enable_ff;
         level_ff     <= fixed_level_ff;
         env_level_ff <= env_step_in ^ {ENV_LVL_W{env_invert_in}};
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.gate_a    = gate_ff[0];
   assign rsp_chan.gate_b    = gate_ff[1];
   assign rsp_chan.gate_c    = gate_ff[2];
   assign rsp_chan.use_env_a = use_env_ff[0];
   assign rsp_chan.use_env_b = use_env_ff[1];
   assign rsp_chan.use_env_c = use_env_ff[2];
   assign rsp_chan.level_a   = level_ff[0];
   assign rsp_chan.level_b   = level_ff[1];
   assign rsp_chan.level_c   = level_ff[2];
   assign rsp_chan.env_level = env_level_ff;

   // ---------------- assertions ----------------
   // a new result only appears right after a tick left the input register
   a_rsp_from_tick : assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff ##1 out_valid_ff |-> $past(in_valid_ff && is_tick))
      else $error("rsp item without a tick");

   // the input side stalls only behind an untaken result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (in_valid_ff && is_tick && out_valid_ff && !rsp_chan.ready))
      else $error("unexpected req stall");

   // stepping stops only in hold mode
   a_env_hold : assert property (@(posedge clock) disable iff (reset)
      !env_stepping_ff |-> env_hold_ff)
      else $error("envelope stopped without hold");

   // the shift register never locks up at zero
   a_lfsr_live : assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("noise LFSR reached zero");

endmodule
`default_nettype wire
